// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants shared by the source text tokenizer modules
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int unsigned FIELD_BITS = 16;

   typedef enum logic [4:0] {
      TOK_COMMENT = 5'd0,
      TOK_NUMBER  = 5'd1,
      TOK_IDENT   = 5'd2,
      TOK_PRINT   = 5'd3,
      TOK_INPUT   = 5'd4,
      TOK_IF      = 5'd5,
      TOK_WHILE   = 5'd6,
      TOK_THEN    = 5'd7,
      TOK_END     = 5'd8,
      TOK_LET     = 5'd9,
      TOK_STRING  = 5'd10,
      TOK_EQEQ    = 5'd11,
      TOK_EQ      = 5'd12,
      TOK_NOTEQ   = 5'd13,
      TOK_LTEQ    = 5'd14,
      TOK_LT      = 5'd15,
      TOK_GTEQ    = 5'd16,
      TOK_GT      = 5'd17,
      TOK_PLUS    = 5'd18,
      TOK_MINUS   = 5'd19,
      TOK_STAR    = 5'd20,
      TOK_SLASH   = 5'd21,
      TOK_LPAREN  = 5'd22,
      TOK_RPAREN  = 5'd23,
      TOK_SEMI    = 5'd24,
      TOK_COLON   = 5'd25,
      TOK_DOT     = 5'd26,
      TOK_ERROR   = 5'd27,
      TOK_EOF     = 5'd28
   } tok_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_UNCLOSED = 2'd1,
      ERR_BANG     = 2'd2,
      ERR_BYTE     = 2'd3
   } err_type;

   localparam logic IN_BYTE = 1'b0;
   localparam logic IN_EOF  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_byte;
   } req_item_type;

   typedef struct packed {
      logic [4:0]            token_kind;
      logic [FIELD_BITS-1:0] line_number;
      logic [FIELD_BITS-1:0] start_column;
      logic [FIELD_BITS-1:0] token_length;
      logic [1:0]            error_reason;
      logic                  last_of_run;
   } rsp_item_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic       eof;
      logic       newline;
      logic       digit;
      logic       word;
      logic       space;
      logic       quote;
      logic       hash;
      logic       equal;
      logic       relop;
      logic       single;
      logic [4:0] single_kind;
      logic [7:0] char_byte;
   } cls_type;

   function automatic cls_type classify(req_item_type it);
      cls_type    c;
      logic [7:0] b;
      b = it.char_byte;
      c = '0;
      c.char_byte   = b;
      c.eof         = (it.kind == IN_EOF);
      c.newline     = (it.kind == IN_BYTE) && (b == 8'd10);
      c.digit       = (b >= "0") && (b <= "9");
      c.word        = c.digit || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
                      || (b == "_");
      c.space       = (b == 8'd32) || (b == 8'd9) || (b == 8'd11) || (b == 8'd12)
                      || (b == 8'd13);
      c.quote       = (b == "\"");
      c.hash        = (b == "#");
      c.equal       = (b == "=");
      c.relop       = (b == "=") || (b == "!") || (b == "<") || (b == ">");
      c.single      = 1'b1;
      case (b)
         "+":     c.single_kind = TOK_PLUS;
         "-":     c.single_kind = TOK_MINUS;
         "*":     c.single_kind = TOK_STAR;
         "/":     c.single_kind = TOK_SLASH;
         "(":     c.single_kind = TOK_LPAREN;
         ")":     c.single_kind = TOK_RPAREN;
         ";":     c.single_kind = TOK_SEMI;
         ":":     c.single_kind = TOK_COLON;
         ".":     c.single_kind = TOK_DOT;
         default: begin
            c.single_kind = TOK_ERROR;
         end
      endcase
      if (c.word || c.space || c.quote || c.hash || c.relop) begin
         c.single = 1'b0;
      end
      return c;
   endfunction

endpackage

// File: design/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// accepts bytes, classifies them and queues them for the scanner
// ----------------------------------------------------------------------------
module stt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stt_pkg::req_item_type req_item,
   output logic                  cls_valid,
   input  logic                  cls_take,
   output stt_pkg::cls_type      cls_item
);

   stt_pkg::cls_type q_ff [2];
   stt_pkg::cls_type q_in;
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = cls_take && cls_valid;
   assign cls_valid = (cnt_ff != 2'd0);
   assign cls_item  = q_ff[rp_ff];
   assign q_in      = stt_pkg::classify(req_item);

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop)
      else $error("pop from empty queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count mismatch");
`endif

endmodule

// File: design/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// scanner state machine; emits up to two tokens per byte through a skid buffer
// ----------------------------------------------------------------------------
module stt_back #(
   parameter int unsigned POSITION_BITS     = 16,
   parameter int unsigned KEYWORD_MAX_CHARS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cls_valid,
   output logic                  cls_take,
   input  stt_pkg::cls_type      cls_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stt_pkg::rsp_item_type rsp_item
);

   localparam int unsigned PB = POSITION_BITS;
   localparam int unsigned KB = 8 * KEYWORD_MAX_CHARS;
   localparam logic [PB-1:0] PMAX = '1;

   typedef enum logic [5:0] {
      M_IDLE    = 6'b000001,
      M_NUM     = 6'b000010,
      M_IDENT   = 6'b000100,
      M_STR     = 6'b001000,
      M_COMMENT = 6'b010000,
      M_OP      = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [4:0]    kind;
      logic [PB-1:0] line;
      logic [PB-1:0] col;
      logic [PB-1:0] len;
      logic [1:0]    reason;
   } tok_type;

   mode_type      mode_ff, mode_in;
   logic [PB-1:0] line_ff, line_in, colc_ff, colc_in, start_ff, start_in, len_ff, len_in;
   logic [KB-1:0] kw_ff, kw_in;
   logic [7:0]    op_ff, op_in;
   logic          has_ff, has_in;

   // output buffer: two slots, each holds one token
   tok_type       ob_ff [2];
   logic          obl_ff [2];
   logic [1:0]    obv_ff, obv_in;
   tok_type       t0, t1, fl;
   logic          e0, e1, fl_e;
   logic [PB-1:0] col_nx, ln;

   function automatic logic [PB-1:0] sat(logic [PB-1:0] v);
      return (v == PMAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [KB-1:0] kwpack(string s);
      logic [KB-1:0] p;
      p = '0;
      for (int i = 0; i < s.len(); i++) begin
         p = {p[KB-9:0], 8'(s[i])};
      end
      return p;
   endfunction

   function automatic logic [4:0] kwkind(logic [KB-1:0] b, logic [PB-1:0] n);
      logic [4:0] k;
      k = stt_pkg::TOK_IDENT;
      if (n == PB'(5) && b == kwpack("print")) k = stt_pkg::TOK_PRINT;
      if (n == PB'(5) && b == kwpack("input")) k = stt_pkg::TOK_INPUT;
      if (n == PB'(2) && b == kwpack("if"))    k = stt_pkg::TOK_IF;
      if (n == PB'(5) && b == kwpack("while")) k = stt_pkg::TOK_WHILE;
      if (n == PB'(4) && b == kwpack("then"))  k = stt_pkg::TOK_THEN;
      if (n == PB'(3) && b == kwpack("end"))   k = stt_pkg::TOK_END;
      if (n == PB'(3) && b == kwpack("let"))   k = stt_pkg::TOK_LET;
      return k;
   endfunction

   // a byte needs room for two tokens; a lone head token may leave this cycle
   assign cls_take = cls_valid && ((obv_ff == 2'b00) || ((obv_ff == 2'b01) && !rsp_stall));
   assign ln       = line_ff;
   assign col_nx   = sat(colc_ff);

   // pending-token flush
   always_comb begin
      fl   = '0;
      fl_e = 1'b1;
      fl.line  = ln;
      fl.col   = start_ff;
      fl.len   = len_ff;
      fl.kind  = stt_pkg::TOK_COMMENT;
      fl.reason = stt_pkg::ERR_NONE;
      unique case (mode_ff)
         M_NUM:     fl.kind = stt_pkg::TOK_NUMBER;
         M_IDENT:   fl.kind = kwkind(kw_ff, len_ff);
         M_STR: begin
            fl.kind   = stt_pkg::TOK_ERROR;
            fl.reason = stt_pkg::ERR_UNCLOSED;
         end
         M_COMMENT: fl.kind = stt_pkg::TOK_COMMENT;
         M_OP: begin
            fl.len = PB'(1);
            if (op_ff == "!") begin
               fl.kind   = stt_pkg::TOK_ERROR;
               fl.reason = stt_pkg::ERR_BANG;
            end else if (op_ff == "=") begin
               fl.kind = stt_pkg::TOK_EQ;
            end else if (op_ff == "<") begin
               fl.kind = stt_pkg::TOK_LT;
            end else begin
               fl.kind = stt_pkg::TOK_GT;
            end
         end
         default: fl_e = 1'b0;
      endcase
   end

   always_comb begin
      logic start_new;
      stt_pkg::cls_type c;
      c         = cls_item;
      start_new = 1'b0;
      mode_in  = mode_ff;
      line_in  = line_ff;
      colc_in  = colc_ff;
      start_in = start_ff;
      len_in   = len_ff;
      kw_in    = kw_ff;
      op_in    = op_ff;
      has_in   = has_ff;
      t0 = fl;
      t1 = '0;
      e0 = 1'b0;
      e1 = 1'b0;
      if (c.eof) begin
         e0 = fl_e;
         e1 = 1'b1;
         t1.kind   = stt_pkg::TOK_EOF;
         t1.line   = has_ff ? sat(line_ff) : line_ff;
         t1.col    = PB'(1);
         t1.len    = '0;
         t1.reason = stt_pkg::ERR_NONE;
         mode_in  = M_IDLE;
         line_in  = PB'(1);
         colc_in  = '0;
         start_in = '0;
         len_in   = '0;
         kw_in    = '0;
         op_in    = '0;
         has_in   = 1'b0;
      end else if (c.newline) begin
         e0 = fl_e;
         mode_in = M_IDLE;
         line_in = sat(line_ff);
         colc_in = '0;
         has_in  = 1'b0;
      end else begin
         has_in  = 1'b1;
         colc_in = col_nx;
         unique case (mode_ff)
            M_NUM: begin
               if (c.digit) len_in = sat(len_ff);
               else begin e0 = 1'b1; start_new = 1'b1; end
            end
            M_IDENT: begin
               if (c.word) begin
                  len_in = sat(len_ff);
                  kw_in  = {kw_ff[KB-9:0], c.char_byte};
               end else begin
                  e0 = 1'b1;
                  start_new = 1'b1;
               end
            end
            M_STR: begin
               if (c.quote) begin
                  e0 = 1'b1;
                  t0.kind = stt_pkg::TOK_STRING;
                  t0.reason = stt_pkg::ERR_NONE;
                  mode_in = M_IDLE;
               end else begin
                  len_in = sat(len_ff);
               end
            end
            M_COMMENT: len_in = sat(len_ff);
            M_OP: begin
               if (c.equal) begin
                  e0 = 1'b1;
                  t0.len = PB'(2);
                  t0.reason = stt_pkg::ERR_NONE;
                  if (op_ff == "=")      t0.kind = stt_pkg::TOK_EQEQ;
                  else if (op_ff == "!") t0.kind = stt_pkg::TOK_NOTEQ;
                  else if (op_ff == "<") t0.kind = stt_pkg::TOK_LTEQ;
                  else                   t0.kind = stt_pkg::TOK_GTEQ;
                  mode_in = M_IDLE;
               end else begin
                  e0 = 1'b1;
                  start_new = 1'b1;
               end
            end
            default: start_new = 1'b1;
         endcase
         if (start_new) begin
            mode_in = M_IDLE;
            if (!c.space) begin
               start_in = col_nx;
               len_in   = PB'(1);
               if (c.hash) mode_in = M_COMMENT;
               else if (c.digit) mode_in = M_NUM;
               else if (c.word) begin
                  mode_in = M_IDENT;
                  kw_in   = KB'(c.char_byte);
               end else if (c.quote) begin
                  mode_in = M_STR;
                  len_in  = '0;
               end else if (c.relop) begin
                  mode_in = M_OP;
                  op_in   = c.char_byte;
               end else begin
                  e1 = 1'b1;
                  t1.kind = c.single_kind;
                  t1.line = ln;
                  t1.col  = col_nx;
                  t1.len  = PB'(1);
                  t1.reason = (c.single_kind == stt_pkg::TOK_ERROR) ?
                              stt_pkg::ERR_BYTE : stt_pkg::ERR_NONE;
               end
            end
         end
      end
   end

   // buffer control: slot 0 is shown first
   always_comb begin
      obv_in = obv_ff;
      if (rsp_valid && !rsp_stall) begin
         obv_in = {1'b0, obv_ff[1]};
      end
      if (cls_take) begin
         obv_in = {e0 && e1, e0 || e1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         line_ff  <= PB'(1);
         colc_ff  <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         kw_ff    <= '0;
         op_ff    <= '0;
         has_ff   <= 1'b0;
         obv_ff   <= 2'b00;
      end else begin
         obv_ff <= obv_in;
         if (cls_take) begin
            mode_ff  <= mode_in;
            line_ff  <= line_in;
            colc_ff  <= colc_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            kw_ff    <= kw_in;
            op_ff    <= op_in;
            has_ff   <= has_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cls_take) begin
         ob_ff[0]  <= e0 ? t0 : t1;
         obl_ff[0] <= !(e0 && e1);
         ob_ff[1]  <= t1;
         obl_ff[1] <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         ob_ff[0]  <= ob_ff[1];
         obl_ff[0] <= obl_ff[1];
      end
   end

   assign rsp_valid = obv_ff[0];
   always_comb begin
      rsp_item              = '0;
      rsp_item.token_kind   = ob_ff[0].kind;
      rsp_item.line_number  = stt_pkg::FIELD_BITS'(ob_ff[0].line);
      rsp_item.start_column = stt_pkg::FIELD_BITS'(ob_ff[0].col);
      rsp_item.token_length = stt_pkg::FIELD_BITS'(ob_ff[0].len);
      rsp_item.error_reason = ob_ff[0].reason;
      rsp_item.last_of_run  = obl_ff[0];
   end

`ifndef ASSERT_OFF
   a_buf_order: assert property (@(posedge clock) disable iff (reset)
      obv_ff[1] |-> obv_ff[0])
      else $error("second slot valid without first");
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      cls_take |-> !obv_ff[1])
      else $error("byte taken while two tokens pending");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter zero");
`endif

endmodule

// File: design/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming lexer: source bytes in, tokens with kind, line, column, length out
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one item per byte (kind 0) or an end of input (kind 1).
//   rsp channel carries tokens; last_of_run marks the final token of an item.
//   an item gives zero, one or two tokens; end of input flushes and adds eof.
// path: an item first waits in the classify queue, then its tokens are
//   registered in the scanner output register before they appear.
// throughput: one item per cycle while items give at most one token and
//   the receiver does not stall; an item that gives two tokens holds the
//   scanner until the single output port has drained its first token.
// reset clears the queue, scanner state and pending tokens; line starts at 1.
// when the receiver stalls, tokens wait in the output register, the two-entry
//   queue fills and then req_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
   parameter int unsigned POSITION_BITS     = 16,
   parameter int unsigned KEYWORD_MAX_CHARS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stt_pkg::rsp_item_type rsp_item
);

   logic             cls_valid, cls_take;
   stt_pkg::cls_type cls_item;

   stt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cls_valid (cls_valid),
      .cls_take  (cls_take),
      .cls_item  (cls_item)
   );

   stt_back #(
      .POSITION_BITS     (POSITION_BITS),
      .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_take  (cls_take),
      .cls_item  (cls_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
